// ===== rtl/lns_pkg.sv =====
// Shared types, constants and saturation helpers of the LIF neuron step block.
`default_nettype none
package lns_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int DECAY_BITS = 16;
	localparam int DATA_W     = 32;
	localparam int DECAY_W    = DECAY_BITS + 1;
	localparam int TIME_W     = DATA_W - 1;
	localparam int FACT_W     = FRAC_BITS + 1;
	localparam int MUL_W      = DATA_W + 1;
	localparam int PROD_W     = 2 * MUL_W;
	localparam int DIVN_W     = DATA_W + 1 + FRAC_BITS;
	localparam int DIVD_W     = DATA_W;
	localparam int DCNT_W     = $clog2(DIVN_W + 1);
	localparam int PC_W       = 5;
	localparam int CIDX_W     = 3;

	localparam logic signed [PROD_W-1:0] MAX32_W = {{(PROD_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
	localparam logic signed [PROD_W-1:0] MIN32_W = {{(PROD_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
	localparam logic signed [PROD_W-1:0] ONE_W   = PROD_W'(1) << FRAC_BITS;
	localparam logic [FACT_W-1:0] ONE_F          = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [DIVN_W-1:0] DIV_2P31       = DIVN_W'(1) << (DATA_W - 1);

	localparam logic [DECAY_W-1:0]       RST_DECAY  = DECAY_W'(655);
	localparam logic signed [DATA_W-1:0] RST_THRESH = DATA_W'(65536);
	localparam logic [TIME_W-1:0]        RST_PERIOD = TIME_W'(131);
	localparam logic [TIME_W-1:0]        RST_DT     = TIME_W'(66);

	typedef enum logic [1:0] {
		REQ_ADD     = 2'd0,
		REQ_TICK    = 2'd1,
		REQ_RESTART = 2'd2
	} req_t;

	typedef enum logic [CIDX_W-1:0] {
		CFG_DECAY   = 3'd0,
		CFG_BIAS    = 3'd1,
		CFG_FLOOR   = 3'd2,
		CFG_THRESH  = 3'd3,
		CFG_PERIOD  = 3'd4,
		CFG_DT      = 3'd5,
		CFG_START   = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [DECAY_W-1:0]       decay;
		logic signed [DATA_W-1:0] bias;
		logic signed [DATA_W-1:0] floor_v;
		logic signed [DATA_W-1:0] thresh;
		logic [TIME_W-1:0]        period;
		logic [TIME_W-1:0]        dt;
		logic signed [DATA_W-1:0] start_v;
	} cfg_t;

	typedef enum logic [4:0] {
		OP_NOP,
		OP_ADD,
		OP_RESTART,
		OP_ITOT,
		OP_MUL_DECAY,
		OP_DV,
		OP_VINT,
		OP_FACT_ONE,
		OP_FACT_ZERO,
		OP_DIV_FACT,
		OP_FACT_Q,
		OP_MUL_SCALE,
		OP_VSCALE,
		OP_OVER_ZERO,
		OP_DIV_OVER,
		OP_OVER_Q,
		OP_REM,
		OP_MUL_REFR,
		OP_REFR_SET,
		OP_FINISH
	} op_t;

	typedef enum logic [1:0] {
		HOLD_NONE,
		HOLD_DIV,
		HOLD_OUT
	} hold_t;

	typedef enum logic [2:0] {
		BR_NEXT,
		BR_ALWAYS,
		BR_DISPATCH,
		BR_REFR_LE0,
		BR_REFR_GE_DT,
		BR_NO_SPIKE,
		BR_DV_ZERO
	} br_t;

	typedef logic [PC_W-1:0] pc_t;

	typedef struct packed {
		op_t   op;
		hold_t hold;
		br_t   br;
		pc_t   target;
	} ucode_t;

	typedef struct packed {
		logic refr_le0;
		logic refr_ge_dt;
		logic spike;
		logic dv_zero;
		logic div_busy;
		logic out_busy;
	} flags_t;

	function automatic logic signed [PROD_W-1:0] ext(input logic signed [DATA_W-1:0] x);
		return {{(PROD_W-DATA_W){x[DATA_W-1]}}, x};
	endfunction

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] x);
		logic signed [DATA_W-1:0] r;
		if (x > MAX32_W)
			r = MAX32_W[DATA_W-1:0];
		else if (x < MIN32_W)
			r = MIN32_W[DATA_W-1:0];
		else
			r = x[DATA_W-1:0];
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/lns_div.sv =====
// Restoring divider, one quotient bit per cycle, unsigned magnitudes.
`default_nettype none
module lns_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [lns_pkg::DIVN_W-1:0]  num,
	input  logic [lns_pkg::DIVD_W-1:0]  den,
	output logic                        busy,
	output logic [lns_pkg::DIVN_W-1:0]  quo
);
	import lns_pkg::*;

	logic [DCNT_W-1:0] cnt_q;
	logic [DIVN_W-1:0] num_q;
	logic [DIVD_W-1:0] rem_q;
	logic [DIVD_W-1:0] den_q;
	logic [DIVD_W:0]   rem_sh;
	logic [DIVD_W:0]   rem_sub;
	logic              ge;

	assign rem_sh  = {rem_q, num_q[DIVN_W-1]};
	assign ge      = rem_sh >= {1'b0, den_q};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign busy    = cnt_q != '0;
	assign quo     = num_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= DCNT_W'(DIVN_W);
		end else if (busy) begin
			cnt_q <= cnt_q - DCNT_W'(1);
		end
	end

	// Shift dividend bits out at the top, quotient bits in at the bottom.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy) begin
			num_q <= {num_q[DIVN_W-2:0], ge};
			rem_q <= ge ? rem_sub[DIVD_W-1:0] : rem_sh[DIVD_W-1:0];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/lns_dp.sv =====
// Neuron datapath: state registers, shared multiplier, divider, result register.
`default_nettype none
module lns_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lns_pkg::op_t                      op,
	input  logic                              take,
	input  logic signed [lns_pkg::DATA_W-1:0] cur_in,
	input  lns_pkg::cfg_t                     cfg,
	output lns_pkg::flags_t                   flags,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              out_spiked,
	output logic signed [lns_pkg::DATA_W-1:0] out_membrane
);
	import lns_pkg::*;

	// architectural state
	logic signed [DATA_W-1:0] v_q, syn_q, refr_q;
	// working registers
	logic signed [DATA_W-1:0] cur_q, w_q, dv_q, over_q, out_mem_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [FACT_W-1:0]        factor_q;
	logic                     spike_q, qneg_q, out_spk_q, out_valid_q;

	logic signed [MUL_W-1:0]  mul_a, mul_b, diff, nv;
	logic signed [PROD_W-1:0] prod_sh_d, prod_sh_f, rsum;
	logic signed [DATA_W-1:0] vsum, over_sat;
	logic [MUL_W-1:0]         nv_mag;
	logic [DIVD_W-1:0]        dv_mag;
	logic                     div_start, div_busy;
	logic [DIVN_W-1:0]        div_num, div_quo;
	logic [DIVD_W-1:0]        div_den;

	assign diff      = {w_q[DATA_W-1], w_q} - {v_q[DATA_W-1], v_q};
	assign nv        = {w_q[DATA_W-1], w_q} - ONE_W[MUL_W-1:0];
	assign nv_mag    = nv[MUL_W-1] ? (~nv + MUL_W'(1)) : nv;
	assign dv_mag    = dv_q[DATA_W-1] ? (~dv_q + DATA_W'(1)) : dv_q;
	assign prod_sh_d = prod_q >>> DECAY_BITS;
	assign prod_sh_f = prod_q >>> FRAC_BITS;
	assign rsum      = $signed({{(PROD_W-TIME_W){1'b0}}, cfg.period}) + prod_sh_f;
	assign vsum      = sat32(ext(v_q) + ext(dv_q));

	always_comb begin
		unique case (op)
			OP_MUL_DECAY: begin
				mul_a = diff;
				mul_b = $signed({{(MUL_W-DECAY_W){1'b0}}, cfg.decay});
			end
			OP_MUL_SCALE: begin
				mul_a = {w_q[DATA_W-1], w_q};
				mul_b = $signed({{(MUL_W-FACT_W){1'b0}}, factor_q});
			end
			OP_MUL_REFR: begin
				mul_a = $signed({{(MUL_W-TIME_W){1'b0}}, cfg.dt});
				mul_b = {over_q[DATA_W-1], over_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// divider operands: refractory fraction, or spike overshoot magnitudes
	always_comb begin
		div_start = 1'b0;
		div_num   = {nv_mag, {FRAC_BITS{1'b0}}};
		div_den   = dv_mag;
		unique case (op)
			OP_DIV_FACT: begin
				div_start = 1'b1;
				div_num   = {{(DIVN_W-TIME_W-FRAC_BITS){1'b0}}, refr_q[TIME_W-1:0],
					{FRAC_BITS{1'b0}}};
				div_den   = {1'b0, cfg.dt};
			end
			OP_DIV_OVER: begin
				div_start = 1'b1;
			end
			default: begin
			end
		endcase
	end

	lns_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quo    (div_quo)
	);

	// truncated signed quotient, saturated
	always_comb begin
		if (qneg_q)
			over_sat = (div_quo > DIV_2P31) ? MIN32_W[DATA_W-1:0] :
				(~div_quo[DATA_W-1:0] + DATA_W'(1));
		else
			over_sat = (div_quo >= DIV_2P31) ? MAX32_W[DATA_W-1:0] : div_quo[DATA_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q         <= '0;
			syn_q       <= '0;
			refr_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (op)
				OP_ADD:      syn_q  <= sat32(ext(syn_q) + ext(cur_q));
				OP_RESTART: begin
					v_q    <= cfg.start_v;
					syn_q  <= '0;
					refr_q <= '0;
				end
				OP_VINT:     refr_q <= sat32(ext(refr_q) -
					$signed({{(PROD_W-TIME_W){1'b0}}, cfg.dt}));
				OP_REFR_SET: refr_q <= sat32(rsum);
				OP_FINISH: begin
					v_q   <= w_q;
					syn_q <= '0;
				end
				default: begin
				end
			endcase
			if (op == OP_FINISH)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			cur_q <= cur_in;
		unique case (op)
			OP_ITOT: begin
				w_q     <= sat32(ext(syn_q) + ext(cfg.bias));
				spike_q <= 1'b0;
			end
			OP_MUL_DECAY, OP_MUL_SCALE, OP_MUL_REFR: prod_q <= mul_a * mul_b;
			OP_DV:        dv_q     <= sat32(prod_sh_d);
			OP_VINT:      w_q      <= (vsum < cfg.floor_v) ? cfg.floor_v : vsum;
			OP_FACT_ONE:  factor_q <= ONE_F;
			OP_FACT_ZERO: factor_q <= '0;
			OP_FACT_Q:    factor_q <= ONE_F - div_quo[FACT_W-1:0];
			OP_VSCALE:    w_q      <= prod_sh_f[DATA_W-1:0];
			OP_OVER_ZERO: over_q   <= '0;
			OP_DIV_OVER:  qneg_q   <= nv[MUL_W-1] ^ dv_q[DATA_W-1];
			OP_OVER_Q:    over_q   <= over_sat;
			OP_REM:       over_q   <= sat32(ONE_W - ext(over_q));
			OP_REFR_SET: begin
				w_q     <= '0;
				spike_q <= 1'b1;
			end
			OP_FINISH: begin
				out_spk_q <= spike_q;
				out_mem_q <= w_q;
			end
			default: begin
			end
		endcase
	end

	assign flags.refr_le0   = refr_q <= $signed(DATA_W'(0));
	assign flags.refr_ge_dt = $signed({refr_q[DATA_W-1], refr_q}) >=
		$signed({2'b00, cfg.dt});
	assign flags.spike      = w_q >= cfg.thresh;
	assign flags.dv_zero    = dv_q == '0;
	assign flags.div_busy   = div_busy;
	assign flags.out_busy   = out_valid_q & ~out_ready;

	assign out_valid    = out_valid_q;
	assign out_spiked   = out_spk_q;
	assign out_membrane = out_mem_q;

endmodule
`default_nettype wire

// ===== rtl/lns_seq.sv =====
// Microcode sequencer: step counter, control store, holds and branches.
`default_nettype none
module lns_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  lns_pkg::flags_t flags,
	input  logic            in_valid,
	input  logic [1:0]      req_type,
	output logic            in_ready,
	output logic            take,
	output lns_pkg::op_t    op
);
	import lns_pkg::*;

	localparam pc_t S_IDLE      = 5'd0;
	localparam pc_t S_ADD       = 5'd1;
	localparam pc_t S_RST       = 5'd2;
	localparam pc_t S_TICK      = 5'd3;
	localparam pc_t S_SCALE     = 5'd12;
	localparam pc_t S_REM       = 5'd19;
	localparam pc_t S_FIN       = 5'd22;

	function automatic ucode_t ucode(input pc_t pc);
		ucode_t w;
		unique case (pc)
			5'd0:  w = '{OP_NOP,       HOLD_NONE, BR_DISPATCH,   S_IDLE};
			5'd1:  w = '{OP_ADD,       HOLD_NONE, BR_ALWAYS,     S_IDLE};
			5'd2:  w = '{OP_RESTART,   HOLD_NONE, BR_ALWAYS,     S_IDLE};
			5'd3:  w = '{OP_ITOT,      HOLD_NONE, BR_NEXT,       S_IDLE};
			5'd4:  w = '{OP_MUL_DECAY, HOLD_NONE, BR_NEXT,       S_IDLE};
			5'd5:  w = '{OP_DV,        HOLD_NONE, BR_NEXT,       S_IDLE};
			5'd6:  w = '{OP_VINT,      HOLD_NONE, BR_NEXT,       S_IDLE};
			5'd7:  w = '{OP_FACT_ONE,  HOLD_NONE, BR_REFR_LE0,   S_SCALE};
			5'd8:  w = '{OP_FACT_ZERO, HOLD_NONE, BR_REFR_GE_DT, S_SCALE};
			5'd9:  w = '{OP_DIV_FACT,  HOLD_NONE, BR_NEXT,       S_IDLE};
			5'd10: w = '{OP_NOP,       HOLD_DIV,  BR_NEXT,       S_IDLE};
			5'd11: w = '{OP_FACT_Q,    HOLD_NONE, BR_NEXT,       S_IDLE};
			5'd12: w = '{OP_MUL_SCALE, HOLD_NONE, BR_NEXT,       S_IDLE};
			5'd13: w = '{OP_VSCALE,    HOLD_NONE, BR_NEXT,       S_IDLE};
			5'd14: w = '{OP_NOP,       HOLD_NONE, BR_NO_SPIKE,   S_FIN};
			5'd15: w = '{OP_OVER_ZERO, HOLD_NONE, BR_DV_ZERO,    S_REM};
			5'd16: w = '{OP_DIV_OVER,  HOLD_NONE, BR_NEXT,       S_IDLE};
			5'd17: w = '{OP_NOP,       HOLD_DIV,  BR_NEXT,       S_IDLE};
			5'd18: w = '{OP_OVER_Q,    HOLD_NONE, BR_NEXT,       S_IDLE};
			5'd19: w = '{OP_REM,       HOLD_NONE, BR_NEXT,       S_IDLE};
			5'd20: w = '{OP_MUL_REFR,  HOLD_NONE, BR_NEXT,       S_IDLE};
			5'd21: w = '{OP_REFR_SET,  HOLD_NONE, BR_NEXT,       S_IDLE};
			5'd22: w = '{OP_FINISH,    HOLD_OUT,  BR_ALWAYS,     S_IDLE};
			default: w = '{OP_NOP,     HOLD_NONE, BR_ALWAYS,     S_IDLE};
		endcase
		return w;
	endfunction

	pc_t    pc_q, pc_d;
	ucode_t word;
	logic   stall;

	assign word  = ucode(pc_q);
	assign stall = (word.hold == HOLD_DIV && flags.div_busy) ||
		(word.hold == HOLD_OUT && flags.out_busy);

	// outputs
	always_comb begin
		in_ready = word.br == BR_DISPATCH;
		take     = in_ready & in_valid;
		op       = stall ? OP_NOP : word.op;
	end

	// next step
	always_comb begin
		pc_d = pc_q + PC_W'(1);
		if (stall) begin
			pc_d = pc_q;
		end else begin
			unique case (word.br)
				BR_NEXT:       pc_d = pc_q + PC_W'(1);
				BR_ALWAYS:     pc_d = word.target;
				BR_REFR_LE0:   if (flags.refr_le0) pc_d = word.target;
				BR_REFR_GE_DT: if (flags.refr_ge_dt) pc_d = word.target;
				BR_NO_SPIKE:   if (!flags.spike) pc_d = word.target;
				BR_DV_ZERO:    if (flags.dv_zero) pc_d = word.target;
				BR_DISPATCH: begin
					pc_d = S_IDLE;
					if (in_valid) begin
						unique case (req_type)
							REQ_ADD:     pc_d = S_ADD;
							REQ_TICK:    pc_d = S_TICK;
							REQ_RESTART: pc_d = S_RST;
							default:     pc_d = S_IDLE;
						endcase
					end
				end
				default:       pc_d = S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= S_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/lif_neuron_step_top.sv =====
// Top level of the leaky integrate-and-fire neuron step block.
//
// One neuron in signed fixed point (32-bit words, FRAC_BITS fraction bits).
// Input stream (s_axis_*): tuser carries the request kind, tdata the current.
//   add     - saturating add of tdata into the synaptic sum, no result.
//   tick    - integrate, clamp at floor, refractory scaling, threshold test;
//             one result beat (m_axis_*): tuser[0] spike, tdata membrane.
//   restart - load the start voltage, clear sum and timer, no result.
//   The unused kind is taken and dropped.
// Config port (cfg_*): decay, bias, floor, threshold, period, step time and
//   start voltage by index; always ready. Write only while no tick is busy.
// Timing: one control step per cycle, except while a step holds for the divider
//   or for the output register. A tick divides out the refractory fraction
//   unless the timer is zero or below or blanks the whole step, and on a spike
//   with nonzero dv it divides out the overshoot as well. The shared bit-serial
//   divider (one quotient bit per cycle, DIVN_W = 49) sets the long cases.
// Stall: the result waits in an output register; the next item is accepted
//   meanwhile, and a following tick holds in its last step until it frees.
// Reset: clears sequencer, state and output valid; config returns to defaults.
`default_nettype none
module lif_neuron_step_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [lns_pkg::DATA_W-1:0]       s_axis_tdata,   // [31:0] current
	input  logic [1:0]                       s_axis_tuser,   // [1:0] req_type
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [lns_pkg::DATA_W-1:0]       m_axis_tdata,   // [31:0] membrane
	output logic [0:0]                       m_axis_tuser,   // [0] spiked
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [lns_pkg::CIDX_W-1:0]       cfg_index,
	input  logic [lns_pkg::DATA_W-1:0]       cfg_data
);
	import lns_pkg::*;

	cfg_t   cfg_q;
	flags_t flags;
	op_t    op;
	logic   take;
	logic   out_spiked;
	logic signed [DATA_W-1:0] out_membrane;

	assign cfg_ready = 1'b1;

	// Config registers; indexes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.decay   <= RST_DECAY;
			cfg_q.bias    <= '0;
			cfg_q.floor_v <= '0;
			cfg_q.thresh  <= RST_THRESH;
			cfg_q.period  <= RST_PERIOD;
			cfg_q.dt      <= RST_DT;
			cfg_q.start_v <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_DECAY:  cfg_q.decay   <= cfg_data[DECAY_W-1:0];
				CFG_BIAS:   cfg_q.bias    <= cfg_data;
				CFG_FLOOR:  cfg_q.floor_v <= cfg_data;
				CFG_THRESH: cfg_q.thresh  <= cfg_data;
				CFG_PERIOD: cfg_q.period  <= cfg_data[TIME_W-1:0];
				CFG_DT:     cfg_q.dt      <= cfg_data[TIME_W-1:0];
				CFG_START:  cfg_q.start_v <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Sequencer: walks the control store, decodes the request kind.
	lns_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.flags    (flags),
		.in_valid (s_axis_tvalid),
		.req_type (s_axis_tuser),
		.in_ready (s_axis_tready),
		.take     (take),
		.op       (op)
	);

	// Datapath: neuron state, multiplier, divider, result register.
	lns_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.op           (op),
		.take         (take),
		.cur_in       (s_axis_tdata),
		.cfg          (cfg_q),
		.flags        (flags),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_spiked   (out_spiked),
		.out_membrane (out_membrane)
	);

	assign m_axis_tdata    = out_membrane;
	assign m_axis_tuser[0] = out_spiked;

endmodule
`default_nettype wire

// ===== rtl/lns_checker.sv =====
// Port-level checker of the LIF neuron step block and its bind.
`default_nettype none
module lns_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_axis_tvalid,
	input logic                       s_axis_tready,
	input logic [1:0]                 s_axis_tuser,
	input logic                       m_axis_tvalid,
	input logic                       m_axis_tready,
	input logic [lns_pkg::DATA_W-1:0] m_axis_tdata,
	input logic [0:0]                 m_axis_tuser
);
	import lns_pkg::*;

	// A fired neuron reports a reset membrane.
	a_spike_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
		else $error("spike beat with nonzero membrane");

	// A tick keeps the input closed on the following cycle.
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tuser == REQ_TICK) |=> !s_axis_tready)
		else $error("input taken during tick");

	// No result appears right after a taken beat: a tick needs many steps.
	a_no_fast_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
		else $error("result rose right after an input beat");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
		(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
		else $error("stalled result beat changed");

endmodule

bind lif_neuron_step_top lns_checker u_lns_checker (.*);
`default_nettype wire
